>>> design/sha_pkg.sv
// Package: SHA-256 types, constants and round functions.
package sha_pkg;

  localparam int WordW = 32;
  localparam int LenW  = 61;

  // Command from the front part to the compression engine
  typedef struct packed {
    logic [511:0] block;
    logic         last;
  } sha_cmd_t;

  typedef logic [WordW-1:0] word_t;

  localparam logic [255:0] HInit = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

>>> design/sha_front.sv
// Front part: packs message bytes into blocks and builds the padding blocks.
module sha_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_has,
  input  logic              in_final,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output sha_pkg::sha_cmd_t cmd
);
  import sha_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StPad1 = 2'd1;  // emit length-only block
  localparam logic [1:0] StPad2 = 2'd2;  // emit padding block after a full block

  logic [1:0]      state;
  logic [511:0]    buf_q;
  logic [LenW-1:0] len;
  logic [5:0]      pos;
  logic [511:0]    buf_b;
  logic [LenW-1:0] len_b;
  logic [511:0]    padded;
  logic [63:0]     bits;
  logic [6:0]      ppos;

  assign pos = len[5:0];
  assign in_ready = (state == StIdle) && (!cmd_valid || cmd_ready);

  // Byte insertion, big-endian within the block
  always_comb begin
    buf_b = buf_q;
    len_b = len;
    if (in_has) begin
      buf_b[511 - 8*pos -: 8] = in_byte;
      len_b = len + LenW'(1);
    end
  end

  // Padded block for the current fill; ppos = byte slot of the 0x80 mark
  always_comb begin
    ppos = {1'b0, len_b[5:0]};
    bits = {len_b, 3'b000};
    padded = buf_b;
    for (int i = 0; i < 64; i++) begin
      if (7'(i) == ppos) padded[511 - 8*i -: 8] = 8'h80;
      else if (7'(i) > ppos) padded[511 - 8*i -: 8] = 8'h00;
    end
    if (ppos < 7'd56) padded[63:0] = bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      len       <= '0;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_valid && cmd_ready) cmd_valid <= 1'b0;
      case (state)
        StIdle: begin
          if (in_valid && in_ready) begin
            buf_q <= buf_b;
            len   <= len_b;
            if (in_final) begin
              cmd_valid <= 1'b1;
              if (in_has && len_b[5:0] == 6'd0) begin
                // byte filled the block; padding follows in its own block
                cmd.block <= buf_b;
                cmd.last  <= 1'b0;
                state     <= StPad2;
              end else if (ppos >= 7'd56) begin
                cmd.block <= padded;
                cmd.last  <= 1'b0;
                state     <= StPad1;
              end else begin
                cmd.block <= padded;
                cmd.last  <= 1'b1;
                len       <= '0;
              end
            end else if (in_has && len_b[5:0] == 6'd0) begin
              cmd_valid <= 1'b1;
              cmd.block <= buf_b;
              cmd.last  <= 1'b0;
            end
          end
        end
        StPad1, StPad2: begin
          if (!cmd_valid || cmd_ready) begin
            cmd_valid <= 1'b1;
            cmd.last  <= 1'b1;
            if (state == StPad2) cmd.block <= {8'h80, 440'd0, len, 3'b000};
            else cmd.block <= {448'd0, len, 3'b000};
            len   <= '0;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

>>> design/sha_queue.sv
// Two-entry queue of block commands between front and engine.
module sha_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  sha_pkg::sha_cmd_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output sha_pkg::sha_cmd_t rd_data
);
  import sha_pkg::*;

  sha_cmd_t   mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule

>>> design/sha_engine.sv
// Back part: 64-round compression, one round per cycle, and digest output.
module sha_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  sha_pkg::sha_cmd_t cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_word,
  output logic [2:0]        out_index,
  output logic              out_last
);
  import sha_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StAdd   = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  logic [1:0]   state;
  logic [5:0]   t;
  logic [255:0] hash;
  logic [255:0] hout;
  word_t        w [16];
  word_t        a, b, c, d, e, f, g, h;
  logic [255:0] round_state;
  logic         last;
  logic [2:0]   idx;
  word_t        wt, s0, s1, t1, t2;

  assign cmd_ready = (state == StIdle);

  // working variables a..h packed, a in the top word
  assign round_state = {a, b, c, d, e, f, g, h};

  // Schedule word for round t; window is a 16-word shift line
  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wt = (t < 6'd16) ? w[0] : w[0] + s0 + w[9] + s1;
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
         + round_k(t) + wt;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  assign out_word  = hout[255 - 32*idx -: 32];
  assign out_index = idx;
  assign out_last  = (idx == 3'd7);
  assign out_valid = (state == StOut);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      hash  <= HInit;
      t     <= '0;
      idx   <= '0;
    end else begin
      case (state)
        StIdle: begin
          if (cmd_valid) begin
            for (int i = 0; i < 16; i++) w[i] <= cmd.block[511 - 32*i -: 32];
            {a, b, c, d, e, f, g, h} <= hash;
            last  <= cmd.last;
            t     <= '0;
            state <= StRound;
          end
        end
        StRound: begin
          // rounds before 16 use the block words; later ones the schedule
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wt;
          {a, b, c, d, e, f, g, h} <= {t1 + t2, a, b, c, d + t1, e, f, g};
          t <= t + 6'd1;
          if (t == 6'd63) state <= StAdd;
        end
        StAdd: begin
          for (int i = 0; i < 8; i++)
            hash[255 - 32*i -: 32] <= hash[255 - 32*i -: 32] + round_state[255 - 32*i -: 32];
          state <= last ? StOut : StIdle;
        end
        StOut: begin
          if (out_ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              hash  <= HInit;
              state <= StIdle;
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // Digest snapshot shown while words are read out
  always_comb hout = hash;
endmodule

>>> design/sha256_message_hasher.sv
// Top level: SHA-256 hasher, byte stream in, digest words out.
// Usage:
//   s_axis carries one message byte per item; tdata[7:0] is the byte,
//   tuser flags whether the byte is present, tlast ends the message.
//   m_axis returns the eight digest words, H0 first; tuser is the word
//   index and tlast marks the eighth word.
// Timing:
//   Each full or padding block passes through the compression engine as
//   a load, 64 rounds at one per cycle and an add; the single round
//   datapath sets the throughput. The front part packs bytes and builds
//   padding while the engine works, through a two-entry block queue,
//   and stalls only when that queue is full or a final item's second
//   padding block is still to be sent. After the last block, the words
//   appear one per cycle while m_axis_tready is high.
// Reset: rst clears the length, the queue and reloads the initial hash.
// Stall: if m_axis_tready is low the current word holds; the engine
//   waits, and input continues until the queue fills.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,  // [0] has_byte
  input  logic        s_axis_tlast,  // is_final
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,  // [2:0] word_index
  output logic        m_axis_tlast   // last_word
);
  import sha_pkg::*;

  sha_cmd_t f_cmd, q_cmd;
  logic     f_valid, f_ready, q_valid, q_ready;

  sha_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_byte(s_axis_tdata), .in_has(s_axis_tuser[0]), .in_final(s_axis_tlast),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
  );

  sha_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cmd)
  );

  sha_engine u_engine (
    .clk, .rst,
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_word(m_axis_tdata), .out_index(m_axis_tuser), .out_last(m_axis_tlast)
  );
endmodule

>>> design/sha_checker.sv
// Port-level checker for the SHA-256 hasher, bound to the top level.
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  // tlast goes with the eighth word only
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("tlast does not match word index");

  // word index steps by one after a taken non-last word
  a_step: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest words not in order");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled word changed");

  // a digest run starts at word zero
  a_start: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> (m_axis_tuser == 3'd0))
    else $error("digest run not started at word zero");
endmodule

bind sha256_message_hasher sha_checker u_sha_checker (.*);
